// ===== rtl/core/png_scanline_unfilter_top_defines.svh =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter: assertion macros
// Shared helpers for the concurrent checks in the unfilter RTL.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_TOP_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_TOP_DEFINES_SVH

// A property checked on every clock edge outside of reset.
`define PSU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked on every clock edge outside of reset.
`define PSU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter: shared package
// Types, codes and small helper functions used by the unfilter modules.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned NUM_CH        = 4;
  localparam int unsigned CMP_W         = 17;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef logic [7:0] byte_t;

  // Filter codes; anything above Paeth is kept as the invalid code.
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [2:0] FILT_BAD   = 3'd5;

  // Color modes.
  localparam logic [2:0] MODE_GREY    = 3'd0;
  localparam logic [2:0] MODE_GREY_A  = 3'd1;
  localparam logic [2:0] MODE_RGB     = 3'd2;
  localparam logic [2:0] MODE_RGBA    = 3'd3;
  localparam logic [2:0] MODE_PALETTE = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COLOR_MODE = 2'd2;

  // One classified stream byte on its way from the front to the back.
  typedef struct packed {
    logic       is_filter;
    logic [2:0] filt;
    logic [1:0] ch;
    logic       first_row;
    logic       pix_last;
    logic       row_last;
    logic       img_last;
    byte_t      data;
  } item_t;

  function automatic logic [2:0] mode_channels(input logic [2:0] mode);
    logic [2:0] n;
    unique case (mode)
      MODE_GREY_A: n = 3'd2;
      MODE_RGB:    n = 3'd3;
      MODE_RGBA:   n = 3'd4;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic byte_t get_lane(input logic [31:0] w, input logic [1:0] ch);
    return w[{ch, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] ch,
                                           input byte_t v);
    logic [31:0] r;
    r = w;
    r[{ch, 3'b000} +: 8] = v;
    return r;
  endfunction

  function automatic byte_t paeth_pick(input byte_t a, input byte_t b, input byte_t c);
    logic signed [10:0] sa, sb, sc, p, da, db, dc;
    byte_t pick;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    p  = sa + sb - sc;
    da = (p > sa) ? p - sa : sa - p;
    db = (p > sb) ? p - sb : sb - p;
    dc = (p > sc) ? p - sc : sc - p;
    if (da <= db && da <= dc) begin
      pick = a;
    end else if (db <= dc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

// ===== rtl/core/psu_front.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter: front end
// Accepts stream bytes, tracks channel, column and row, and tags each byte.
// ----------------------------------------------------------------------------
module psu_front #(
  parameter int unsigned MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COL_W     = 12,
  parameter int unsigned ADDR_W    = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  psu_pkg::byte_t      s_data_i,
  input  logic [12:0]         cfg_width_i,
  input  logic [15:0]         cfg_height_i,
  input  logic [2:0]          cfg_mode_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output psu_pkg::item_t      push_item_o,
  output logic [ADDR_W-1:0]   push_addr_o
);
  import psu_pkg::*;

  logic             expect_q, expect_d;
  logic [2:0]       filt_q, filt_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [1:0]       ch_q, ch_d;
  logic [15:0]      row_q, row_d;

  logic             accept;
  logic [CMP_W-1:0] width_raw, width_eff, col_next;
  logic [16:0]      row_next;
  logic [2:0]       nch;
  logic             pix_last, row_last, img_last;
  logic [2:0]       filt_code;

  assign s_ready_o    = push_ready_i;
  assign push_valid_o = s_valid_i;
  assign accept       = s_valid_i & push_ready_i;

  always_comb begin
    width_raw = CMP_W'(cfg_width_i);
    if (width_raw == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    col_next  = CMP_W'(col_q) + CMP_W'(1);
    row_next  = {1'b0, row_q} + 17'd1;
    nch       = mode_channels(cfg_mode_i);
    pix_last  = ({1'b0, ch_q} + 3'd1) >= nch;
    row_last  = pix_last & (col_next >= width_eff);
    // A height of zero behaves as one since the compare is then always true.
    img_last  = row_last & (row_next >= {1'b0, cfg_height_i});
    filt_code = (s_data_i > 8'd4) ? FILT_BAD : s_data_i[2:0];
  end

  always_comb begin
    push_item_o.is_filter = expect_q;
    push_item_o.filt      = expect_q ? filt_code : filt_q;
    push_item_o.ch        = ch_q;
    push_item_o.first_row = (row_q == '0);
    push_item_o.pix_last  = pix_last;
    push_item_o.row_last  = row_last;
    push_item_o.img_last  = img_last;
    push_item_o.data      = s_data_i;
    push_addr_o           = ADDR_W'({col_q, ch_q});
  end

  always_comb begin
    expect_d = expect_q;
    filt_d   = filt_q;
    col_d    = col_q;
    ch_d     = ch_q;
    row_d    = row_q;
    if (accept) begin
      if (expect_q) begin
        expect_d = 1'b0;
        filt_d   = filt_code;
        col_d    = '0;
        ch_d     = '0;
      end else if (!pix_last) begin
        ch_d = ch_q + 2'd1;
      end else begin
        ch_d = '0;
        if (row_last) begin
          col_d    = '0;
          expect_d = 1'b1;
          row_d    = img_last ? '0 : row_next[15:0];
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      filt_q   <= FILT_NONE;
      col_q    <= '0;
      ch_q     <= '0;
      row_q    <= '0;
    end else begin
      expect_q <= expect_d;
      filt_q   <= filt_d;
      col_q    <= col_d;
      ch_q     <= ch_d;
      row_q    <= row_d;
    end
  end

endmodule

// ===== rtl/core/psu_queue.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter: item queue
// Short FIFO that lets the front end and the back end stall independently.
// ----------------------------------------------------------------------------
module psu_queue #(
  parameter int unsigned ADDR_W = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  psu_pkg::item_t      push_item_i,
  input  logic [ADDR_W-1:0]   push_addr_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output psu_pkg::item_t      pop_item_o,
  output logic [ADDR_W-1:0]   pop_addr_o
);
  import psu_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             items_q [QUEUE_DEPTH];
  logic [ADDR_W-1:0] addrs_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q < CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = items_q[rd_ptr_q];
  assign pop_addr_o   = addrs_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      items_q[wr_ptr_q] <= push_item_i;
      addrs_q[wr_ptr_q] <= push_addr_i;
    end
  end

endmodule

// ===== rtl/core/psu_back.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter: back end
// Line store, filter reconstruction, RGBA expansion and the output register.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_top_defines.svh"

module psu_back #(
  parameter int unsigned MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ADDR_W    = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  psu_pkg::item_t      q_item_i,
  input  logic [ADDR_W-1:0]   q_addr_i,
  input  logic [2:0]          mode_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [31:0]         m_pixel_o,
  output logic                m_row_end_o,
  output logic                m_image_end_o,
  output logic                m_bad_o
);
  import psu_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * NUM_CH;

  byte_t             store_mem [STORE_DEPTH];
  byte_t             rd_q;

  logic              b1_valid_q, b1_valid_d;
  item_t             b1_item_q;
  logic [ADDR_W-1:0] b1_addr_q;

  logic [31:0]       left_q, left_d, ul_q, ul_d, cur_q, cur_d;

  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_pix_q;
  logic              out_row_q, out_img_q, out_bad_q;

  logic              emits, out_free, b1_adv, pop, store_we, bad;
  byte_t             lane_left, lane_ul, lane_up, pred, val;
  logic [8:0]        sum9;
  logic [31:0]       cur_new, ul_new, pix_fmt;

  function automatic logic [31:0] expand(input logic [31:0] p, input logic [2:0] mode);
    byte_t r, g, b, a;
    r = p[7:0];
    g = p[15:8];
    b = p[23:16];
    a = p[31:24];
    unique case (mode)
      MODE_GREY_A: begin
        a = g;
        g = r;
        b = r;
      end
      MODE_RGB: a = 8'd255;
      MODE_RGBA: ;
      MODE_PALETTE: begin
        g = '0;
        b = '0;
        a = 8'd255;
      end
      default: begin
        g = r;
        b = r;
        a = 8'd255;
      end
    endcase
    return {a, b, g, r};
  endfunction

  // Handshake between queue, reconstruction stage and output register.
  assign emits     = ~b1_item_q.is_filter & b1_item_q.pix_last;
  assign out_free  = ~out_valid_q | m_ready_i;
  assign b1_adv    = b1_valid_q & (~emits | out_free);
  assign q_ready_o = ~b1_valid_q | b1_adv;
  assign pop       = q_valid_i & q_ready_o;
  assign store_we  = b1_adv & ~b1_item_q.is_filter;

  always_comb begin
    lane_left = get_lane(left_q, b1_item_q.ch);
    lane_ul   = get_lane(ul_q, b1_item_q.ch);
    lane_up   = b1_item_q.first_row ? '0 : rd_q;
    sum9      = {1'b0, lane_left} + {1'b0, lane_up};
    bad       = (b1_item_q.filt > FILT_PAETH);
    unique case (b1_item_q.filt)
      FILT_SUB:   pred = lane_left;
      FILT_UP:    pred = lane_up;
      FILT_AVG:   pred = sum9[8:1];
      FILT_PAETH: pred = paeth_pick(lane_left, lane_up, lane_ul);
      default:    pred = '0;
    endcase
    val     = bad ? '0 : b1_item_q.data + pred;
    cur_new = put_lane(cur_q, b1_item_q.ch, val);
    // The byte above this column serves as upper-left for the next column.
    ul_new  = put_lane(ul_q, b1_item_q.ch, lane_up);
    pix_fmt = expand(cur_new, mode_i);
  end

  always_comb begin
    b1_valid_d = b1_valid_q;
    if (pop) begin
      b1_valid_d = 1'b1;
    end else if (b1_adv) begin
      b1_valid_d = 1'b0;
    end

    left_d = left_q;
    ul_d   = ul_q;
    cur_d  = cur_q;
    if (b1_adv) begin
      if (b1_item_q.is_filter) begin
        left_d = '0;
        ul_d   = '0;
        cur_d  = '0;
      end else begin
        ul_d = ul_new;
        if (b1_item_q.pix_last) begin
          left_d = cur_new;
          cur_d  = '0;
        end else begin
          cur_d = cur_new;
        end
      end
    end

    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = b1_adv & emits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      ul_q        <= '0;
      cur_q       <= '0;
    end else begin
      b1_valid_q  <= b1_valid_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      ul_q        <= ul_d;
      cur_q       <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_item_q <= q_item_i;
      b1_addr_q <= q_addr_i;
    end
    if (out_free && b1_adv && emits) begin
      out_pix_q <= pix_fmt;
      out_row_q <= b1_item_q.row_last;
      out_img_q <= b1_item_q.img_last;
      out_bad_q <= bad;
    end
  end

  // Line store: one write from the reconstruction stage, one registered read
  // issued as an item enters that stage.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[b1_addr_q] <= val;
    end
    if (pop) begin
      rd_q <= store_mem[q_addr_i];
    end
  end

  assign m_valid_o     = out_valid_q;
  assign m_pixel_o     = out_pix_q;
  assign m_row_end_o   = out_row_q;
  assign m_image_end_o = out_img_q;
  assign m_bad_o       = out_bad_q;

  `PSU_ASSERT_IMP(a_filter_clears, b1_adv && b1_item_q.is_filter, ##1 (left_q == '0 && ul_q == '0 && cur_q == '0), "filter byte did not clear pixel state")
  `PSU_ASSERT_IMP(a_pixel_clears, b1_adv && emits, ##1 (cur_q == '0 && out_valid_q), "finished pixel not moved to output")
  `PSU_ASSERT_IMP(a_bad_zero, out_valid_q && out_bad_q, out_pix_q[7:0] == '0, "bad filter row gave a nonzero sample")
  `PSU_ASSERT_IMP(a_img_row_end, out_valid_q && out_img_q, out_row_q, "image end without row end")

endmodule

// ===== rtl/core/png_scanline_unfilter_top.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter: top level
// Undoes PNG row filters on an inflated byte stream and emits RGBA pixels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] stream byte (filter type or filtered sample)
//  m_axis    out        tdata RGBA pixel, tlast row end, tuser image end / bad filter
//  cfg       in         cfg_index_i register index, cfg_data_i write data
//
//  One byte is accepted per cycle while the queue has room. After its last byte a pixel
//  passes the queue, the reconstruction stage and the output register. The rate is set
//  by the reconstruction stage, which handles one byte per cycle while the output
//  register is free, with a line store of one read and one write port; the read is
//  registered as an item enters the stage. Reset clears counters and pixel state; the
//  line store is not cleared and row 0 ignores what it reads. A stall on m_axis fills
//  the output register, the stage and a two-beat queue before s_axis_tready drops.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top #(
  parameter int unsigned MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [0] image_end, [1] bad_filter
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import psu_pkg::*;

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ADDR_W = COL_W + $clog2(NUM_CH);

  logic [12:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [2:0]  mode_q, mode_d;

  logic              f_valid, f_ready;
  item_t             f_item;
  logic [ADDR_W-1:0] f_addr;
  logic              b_valid, b_ready;
  item_t             b_item;
  logic [ADDR_W-1:0] b_addr;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMG_WIDTH:  width_d  = cfg_data_i[12:0];
        CFG_IMG_HEIGHT: height_d = cfg_data_i;
        CFG_COLOR_MODE: mode_d   = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 16'd1;
      mode_q   <= MODE_RGB;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
    end
  end

  psu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .cfg_mode_i   (mode_q),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_item_o  (f_item),
    .push_addr_o  (f_addr)
  );

  psu_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .push_addr_i  (f_addr),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item),
    .pop_addr_o   (b_addr)
  );

  psu_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (b_valid),
    .q_ready_o     (b_ready),
    .q_item_i      (b_item),
    .q_addr_i      (b_addr),
    .mode_i        (mode_q),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_pixel_o     (m_axis_tdata),
    .m_row_end_o   (m_axis_tlast),
    .m_image_end_o (m_axis_tuser[0]),
    .m_bad_o       (m_axis_tuser[1])
  );

endmodule

// ===== dv/tb_png_scanline_unfilter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter: testbench
// Sends filtered scanlines over the byte stream and predicts every RGBA pixel
// with an independent unfilter model. Each pixel is checked field by field.
// Directed tests cover each filter type, bad filter bytes, out-of-range
// settings, register changes in the middle of a row, a long output stall and
// a very tall image. Random images with random gaps on both sides follow.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter_top;
  import psu_pkg::*;

  localparam int unsigned LINE_PIXELS     = psu_pkg::MAX_WIDTH_DEF;
  localparam int unsigned LINE_BYTES      = LINE_PIXELS * 4;
  localparam int unsigned RANDOM_BYTES    = 1550;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam logic [7:0]  ALPHA_OPAQUE    = 8'd255;
  // Sample bytes of the directed filter rows, four per row, lowest byte first.
  localparam logic [159:0] FILTER_SAMPLES =
    160'hFF00807F_01FEFF00_8080FFFF_0001FE7F_FFFF0080;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } rgba_pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] stream_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;   // [0] image_end, [1] bad_filter
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  png_scanline_unfilter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Register copies, reset values of the block.
  logic [12:0] width_reg  = 13'd1;
  logic [15:0] height_reg = 16'd1;
  logic [2:0]  mode_reg   = MODE_RGB;

  // Unfilter state.
  logic [7:0]  line_above [LINE_BYTES];
  logic [31:0] left_px     = '0;
  logic [31:0] upleft_px   = '0;
  logic [31:0] cur_px      = '0;
  logic [2:0]  row_filt    = FILT_NONE;
  int unsigned col_cnt     = 0;
  int unsigned lane_cnt    = 0;
  int unsigned row_cnt     = 0;
  bit          want_filter = 1'b1;

  rgba_pixel_t pending_pixels [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  bit          no_gaps        = 1'b0;
  bit          hold_out_req   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned lanes_for_mode(input logic [2:0] mode);
    case (mode)
      MODE_GREY_A: return 2;
      MODE_RGB:    return 3;
      MODE_RGBA:   return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic int unsigned row_pixels();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_PIXELS) return LINE_PIXELS;
    return width_reg;
  endfunction

  function automatic logic [7:0] random_sample();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int ia, ib, ic, p, da, db, dc;
    ia = a;
    ib = b;
    ic = c;
    p  = ia + ib - ic;
    da = (p > ia) ? p - ia : ia - p;
    db = (p > ib) ? p - ib : ib - p;
    dc = (p > ic) ? p - ic : ic - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Advances the unfilter state by one accepted byte and queues the pixel it
  // completes, if any.
  function automatic void unfilter_byte(input logic [7:0] value);
    int unsigned width, height, lane, col, idx;
    logic [7:0]  up, lf, ul, pred, sample;
    logic        bad, row_last, img_last;
    rgba_pixel_t px;
    width  = row_pixels();
    height = (height_reg == 0) ? 1 : height_reg;
    if (want_filter) begin
      row_filt    = (value > 4) ? FILT_BAD : value[2:0];
      want_filter = 1'b0;
      left_px     = '0;
      upleft_px   = '0;
      cur_px      = '0;
      lane_cnt    = 0;
      col_cnt     = 0;
      return;
    end
    lane = lane_cnt;
    col  = (col_cnt >= LINE_PIXELS) ? LINE_PIXELS - 1 : col_cnt;
    idx  = col * 4 + lane;
    up   = (row_cnt != 0) ? line_above[idx] : 8'h00;
    lf   = left_px[lane*8 +: 8];
    ul   = upleft_px[lane*8 +: 8];
    bad  = (row_filt == FILT_BAD);
    case (row_filt)
      FILT_SUB:   pred = lf;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((int'(lf) + int'(up)) >> 1);
      FILT_PAETH: pred = paeth_choice(lf, up, ul);
      default:    pred = 8'h00;
    endcase
    sample = bad ? 8'h00 : value + pred;
    // The byte above this column is the upper-left one for the next column.
    upleft_px[lane*8 +: 8] = up;
    line_above[idx]        = sample;
    cur_px[lane*8 +: 8]    = sample;
    if (lane + 1 < lanes_for_mode(mode_reg)) begin
      lane_cnt = lane + 1;
      return;
    end
    px.red   = cur_px[7:0];
    px.green = cur_px[15:8];
    px.blue  = cur_px[23:16];
    px.alpha = cur_px[31:24];
    case (mode_reg)
      MODE_GREY_A: begin
        px.alpha = cur_px[15:8];
        px.green = cur_px[7:0];
        px.blue  = cur_px[7:0];
      end
      MODE_RGB: px.alpha = ALPHA_OPAQUE;
      MODE_RGBA: ;
      MODE_PALETTE: begin
        px.green = 8'h00;
        px.blue  = 8'h00;
        px.alpha = ALPHA_OPAQUE;
      end
      default: begin
        px.green = px.red;
        px.blue  = px.red;
        px.alpha = ALPHA_OPAQUE;
      end
    endcase
    row_last      = (col_cnt + 1 >= width);
    img_last      = row_last && (row_cnt + 1 >= height);
    px.row_end    = row_last;
    px.image_end  = img_last;
    px.bad_filter = bad;
    pending_pixels.push_back(px);
    left_px  = cur_px;
    cur_px   = '0;
    lane_cnt = 0;
    if (row_last) begin
      col_cnt     = 0;
      want_filter = 1'b1;
      row_cnt     = img_last ? 0 : ((row_cnt + 1) & 16'hFFFF);
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    rgba_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel 0x%08h arrived with none expected", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("red", want.red, m_axis_tdata[7:0]);
        check_field("green", want.green, m_axis_tdata[15:8]);
        check_field("blue", want.blue, m_axis_tdata[23:16]);
        check_field("alpha", want.alpha, m_axis_tdata[31:24]);
        check_field("row_end", want.row_end, m_axis_tlast);
        check_field("image_end", want.image_end, m_axis_tuser[0]);
        check_field("bad_filter", want.bad_filter, m_axis_tuser[1]);
      end
    end
  end

  // Output side: random stalls, plus one long hold when a test asks for it.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_out_req) begin
        hold_out_req = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[png_scanline_unfilter_top] ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    unfilter_byte(value);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_IMG_WIDTH:  width_reg  = data[12:0];
      CFG_IMG_HEIGHT: height_reg = data;
      CFG_COLOR_MODE: mode_reg   = data[2:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [15:0] width, input logic [15:0] height,
                              input logic [2:0] mode);
    write_reg(CFG_IMG_WIDTH, width);
    write_reg(CFG_IMG_HEIGHT, height);
    write_reg(CFG_COLOR_MODE, 16'(mode));
  endtask

  // The block can still be busy after the last pixel, so the task keeps waiting once no pixel is expected.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_row();
    int unsigned count;
    count = row_pixels() * lanes_for_mode(mode_reg);
    if ($urandom_range(0, 19) < 18) begin
      send_byte(8'($urandom_range(0, 4)));
    end else begin
      send_byte(8'($urandom_range(5, 255)));
    end
    repeat (count) send_byte(random_sample());
  endtask

  task automatic test_reset_settings();
    send_byte(8'(FILT_NONE));
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'(FILT_SUB));
    repeat (3) send_byte(random_sample());
    wait_drained();
  endtask

  task automatic test_each_filter();
    set_geometry(16'd2, 16'd5, MODE_GREY_A);
    for (int f = 0; f < 5; f++) begin
      send_byte(8'(f));
      for (int k = 0; k < 4; k++) send_byte(FILTER_SAMPLES[(f*4+k)*8 +: 8]);
    end
    wait_drained();
  endtask

  // Bad rows reconstruct to zero, so the Up row after them sees zeros above.
  task automatic test_bad_filter();
    set_geometry(16'd1, 16'd3, MODE_RGBA);
    send_byte(8'd5);
    repeat (4) send_byte(random_sample());
    send_byte(8'hFF);
    repeat (4) send_byte(random_sample());
    send_byte(8'(FILT_UP));
    repeat (4) send_byte(random_sample());
    wait_drained();
  endtask

  // Width 0 acts as 1, height 0 as 1 and an unknown mode as grey.
  task automatic test_odd_settings();
    set_geometry(16'hE000, 16'd0, 3'd7);
    send_byte(8'(FILT_SUB));
    send_byte(8'hC3);
    send_byte(8'(FILT_PAETH));
    send_byte(8'h3C);
    wait_drained();
  endtask

  task automatic test_midrow_change();
    set_geometry(16'd4, 16'd1, MODE_RGB);
    send_byte(8'(FILT_SUB));
    repeat (3) send_byte(random_sample());
    wait_drained();
    // The row now ends on the next pixel, which has four channels.
    write_reg(CFG_IMG_WIDTH, 16'd2);
    write_reg(CFG_COLOR_MODE, 16'(MODE_RGBA));
    repeat (4) send_byte(random_sample());
    send_byte(8'(FILT_AVG));
    repeat (2) send_byte(random_sample());
    wait_drained();
    // Switching to grey in the middle of a pixel closes it on the next byte.
    write_reg(CFG_COLOR_MODE, 16'(MODE_GREY));
    repeat (2) send_byte(random_sample());
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    set_geometry(16'd8, 16'd2, MODE_RGB);
    no_gaps      = 1'b1;
    hold_out_req = 1'b1;
    repeat (2) send_random_row();
    wait_drained();
    no_gaps = 1'b0;
  endtask

  // Full height, cut short after a few rows by lowering the height.
  task automatic test_tall_image();
    set_geometry(16'd3, 16'hFFFF, MODE_RGB);
    repeat (3) send_random_row();
    wait_drained();
    write_reg(CFG_IMG_HEIGHT, 16'd1);
    send_random_row();
    wait_drained();
  endtask

  task automatic test_random_images();
    int unsigned start, roll, width, height, rows;
    logic [2:0]  mode;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      roll   = $urandom_range(0, 99);
      height = $urandom_range(0, 4);
      if (roll < 5) begin
        width = 0;
      end else if (roll < 75) begin
        width = $urandom_range(1, 8);
      end else if (roll < 97) begin
        width = $urandom_range(9, 32);
      end else begin
        width  = $urandom_range(33, 100);
        height = 1;
      end
      mode = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      set_geometry(16'(width | ($urandom_range(0, 7) << 13)), 16'(height), mode);
      no_gaps = ($urandom_range(0, 4) == 0);
      rows    = (height == 0) ? 1 : height;
      repeat (rows) send_random_row();
      wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_IMG_WIDTH;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_each_filter();
    test_bad_filter();
    test_odd_settings();
    test_midrow_change();
    test_output_backpressure();
    test_tall_image();
    test_random_images();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[png_scanline_unfilter_top] OK");
    end else begin
      $display("[png_scanline_unfilter_top] ERROR");
    end
    $finish;
  end

endmodule
